### src/mexp_pkg.sv
// shared types and constants for the modular exponentiation core
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int EXP_BITS  = 63;
    localparam int MOD_BITS  = 31;
    localparam int BASE_BITS = 63;
    localparam int RES_BITS  = 31;
    localparam int CFG_BITS  = 31;

    localparam int RED_CNT_W = $clog2(BASE_BITS);
    localparam int MUL_CNT_W = $clog2(MOD_BITS + 1);

    localparam logic [CFG_BITS-1:0] MODULUS_RESET = 31'd1000000007;

    localparam logic OP_POWER   = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_FINISH = 5'b10000
    } mexp_state_t;

    typedef struct packed {
        logic load;
        logic red_step;
        logic red_last;
        logic mul_start;
        logic mul_commit;
        logic out_load;
    } mexp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic out_free;
    } mexp_status_t;

endpackage

### src/mexp_mulmod.sv
// iterative modular multiplier, one bit of b per cycle, msb first
// depends on mexp_pkg
`timescale 1ns / 1ps

module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MOD_BITS-1:0] a,
    input  logic [MOD_BITS-1:0] b,
    input  logic [MOD_BITS-1:0] m,
    output logic                done,
    output logic [MOD_BITS-1:0] r
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MOD_BITS-1:0]  r_reg, r_next;
    logic [MOD_BITS-1:0]  a_reg, a_next;
    logic [MOD_BITS-1:0]  b_reg, b_next;

    logic [MOD_BITS:0]    dbl;
    logic [MOD_BITS:0]    dbl_red;
    logic [MOD_BITS:0]    sum;
    logic [MOD_BITS:0]    sum_red;
    logic [MOD_BITS:0]    m_ext;

    // r = 2r + bit*a, each partial kept below m
    always_comb
    begin
        m_ext   = {1'b0, m};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (b_reg[MOD_BITS-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = MUL_CNT_W'(MOD_BITS);
            r_next    = '0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red[MOD_BITS-1:0];
            b_next   = {b_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

### src/mexp_datapath.sv
// datapath: modulus register, base reduction, exponent shifter, two multipliers
// depends on mexp_pkg and mexp_mulmod
`timescale 1ns / 1ps

module mexp_datapath
    import mexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mexp_cmd_t            cmd,
    output mexp_status_t         status,
    input  logic                 cfg_write,
    input  logic [CFG_BITS-1:0]  cfg_modulus,
    input  logic                 in_opcode,
    input  logic [BASE_BITS-1:0] in_base,
    input  logic [EXP_BITS-1:0]  in_exponent,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RES_BITS-1:0]  out_result
);

    logic [MOD_BITS-1:0]  m_reg;
    logic [BASE_BITS-1:0] base_reg;
    logic [MOD_BITS-1:0]  rem_reg;
    logic [EXP_BITS-1:0]  exp_reg;
    logic [MOD_BITS-1:0]  acc_reg;
    logic [MOD_BITS-1:0]  sq_reg;
    logic [RES_BITS-1:0]  res_reg;
    logic                 out_valid_reg, out_valid_next;

    logic [MOD_BITS:0]    rem_sh;
    logic [MOD_BITS:0]    rem_red;
    logic [63:0]          inv_exp;
    logic [MOD_BITS-1:0]  acc_prod;
    logic [MOD_BITS-1:0]  sq_prod;
    logic                 acc_done;
    logic                 sq_done;

    // one restoring step of base mod m, and the inverse exponent m - 2
    always_comb
    begin
        rem_sh  = {rem_reg, base_reg[BASE_BITS-1]};
        rem_red = (rem_sh >= {1'b0, m_reg}) ? (rem_sh - {1'b0, m_reg}) : rem_sh;
        inv_exp = (m_reg >= MOD_BITS'(2)) ? 64'(m_reg - MOD_BITS'(2)) : '0;
    end

    mexp_mulmod u_acc_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (acc_reg),
        .b     (sq_reg),
        .m     (m_reg),
        .done  (acc_done),
        .r     (acc_prod)
    );

    mexp_mulmod u_sq_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (sq_reg),
        .b     (sq_reg),
        .m     (m_reg),
        .done  (sq_done),
        .r     (sq_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= MODULUS_RESET[MOD_BITS-1:0];
        end
        else if (cfg_write)
        begin
            m_reg <= cfg_modulus[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= in_base;
            rem_reg  <= '0;
            acc_reg  <= MOD_BITS'(1);
            exp_reg  <= (in_opcode == OP_INVERSE) ? inv_exp[EXP_BITS-1:0] : in_exponent;
        end
        if (cmd.red_step)
        begin
            base_reg <= {base_reg[BASE_BITS-2:0], 1'b0};
            rem_reg  <= rem_red[MOD_BITS-1:0];
        end
        if (cmd.red_last)
        begin
            sq_reg <= rem_red[MOD_BITS-1:0];
        end
        if (cmd.mul_commit)
        begin
            if (exp_reg[0])
            begin
                acc_reg <= acc_prod;
            end
            sq_reg  <= sq_prod;
            exp_reg <= exp_reg >> 1;
        end
        if (cmd.out_load)
        begin
            res_reg <= (m_reg == '0) ? '0 : RES_BITS'(acc_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.mul_done = acc_done;
    assign status.exp_zero = (exp_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_result      = res_reg;

    a_units_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        acc_done == sq_done)
        else $error("multipliers out of step");

    a_sq_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start && (m_reg != '0) |-> sq_reg < m_reg)
        else $error("running square not reduced");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start && (m_reg != '0) |-> (acc_reg < m_reg) || (acc_reg == MOD_BITS'(1)))
        else $error("accumulator not reduced");

endmodule

### src/mexp_ctrl.sv
// controller state machine: sequences reduction, square-and-multiply and output
// depends on mexp_pkg
`timescale 1ns / 1ps

module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  mexp_status_t status,
    output mexp_cmd_t    cmd
);

    mexp_state_t          state_reg, state_next;
    logic [RED_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.red_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == RED_CNT_W'(BASE_BITS - 1))
                begin
                    cmd.red_last = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_commit = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                // wait for the output slot to free up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_REDUCE)
        else $error("load did not start reduction");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result written over a pending word");

endmodule

### src/modular_exponentiation_core.sv
// top level of the modular exponentiation core
// depends on mexp_pkg, mexp_ctrl, mexp_datapath
`timescale 1ns / 1ps

// usage:
// - input channel in_valid/in_ready carries opcode, base_value, exponent_value;
//   opcode power raises base to exponent, opcode inverse uses modulus - 2
// - output channel out_valid/out_ready carries one result_value per input word
// - cfg_valid/cfg_ready writes the modulus; write only while the core is idle
// - one request at a time: in_ready is high only between requests
// - processing: bit-serial base reduction, then one square-and-multiply step per
//   exponent bit up to the highest set bit, with two modular multipliers running
//   side by side, plus control
// - a finished result sits in an output register; a stalled receiver holds the
//   core in its final state, but a new request may be taken once that word is
//   loaded and still waiting
// - reset clears control state and sets the modulus to 1000000007

module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_BITS-1:0]  modulus,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [BASE_BITS-1:0] base_value,
    input  logic [EXP_BITS-1:0]  exponent_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RES_BITS-1:0]  result_value
);

    mexp_cmd_t    cmd;
    mexp_status_t status;

    assign cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_modulus (modulus),
        .in_opcode   (opcode),
        .in_base     (base_value),
        .in_exponent (exponent_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (result_value)
    );

endmodule

### tb/sv/testbench.sv
// testbench for modular_exponentiation_core: directed table, modulus extremes, then random requests
// checks every result word against its table value if given, else an in-bench square-and-multiply predictor
// depends on mexp_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
    import mexp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 200;

    typedef struct {
        logic                 op;
        logic [BASE_BITS-1:0] base;
        logic [EXP_BITS-1:0]  expo;
        logic                 has_exp;
        logic [RES_BITS-1:0]  exp_val;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_BITS-1:0]  modulus = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 opcode = 1'b0;
    logic [BASE_BITS-1:0] base_value = '0;
    logic [EXP_BITS-1:0]  exponent_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [RES_BITS-1:0]  result_value;

    logic [CFG_BITS-1:0]  cur_modulus = MODULUS_RESET;
    logic [RES_BITS-1:0]  pending_results[$];
    int                   error_count = 0;
    int                   idle_cycles = 0;
    int                   rx_wait = 0;
    int                   rx_count = 0;
    int                   rx_seen = 0;
    stim_row_t            directed_rows[$];

    modular_exponentiation_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .modulus        (modulus),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_value   (result_value)
    );

    always #5 clk = ~clk;

    function automatic logic [RES_BITS-1:0] mod_power(logic op, logic [BASE_BITS-1:0] b,
                                                      logic [EXP_BITS-1:0] e,
                                                      logic [CFG_BITS-1:0] m);
        logic [63:0] mm;
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] ex;
        mm = 64'(m);
        if (mm == 64'd0)
            return '0;
        ex = 64'(e);
        if (op == OP_INVERSE)
            ex = (mm >= 64'd2) ? mm - 64'd2 : 64'd0;
        acc = 64'd1;
        sq = 64'(b) % mm;
        for (int i = 0; i < EXP_BITS; i++)
        begin
            if (ex[i])
                acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
        end
        return acc[RES_BITS-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [RES_BITS-1:0] got,
                                   logic [RES_BITS-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic write_modulus(logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        modulus   <= value;
        do @(posedge clk); while (!cfg_ready);
        cur_modulus = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // one request word; expected value is the typed one if given, else predicted
    task automatic send_request(stim_row_t row);
        logic [RES_BITS-1:0] want;
        @(negedge clk);
        repeat ($urandom_range(0, 3)) @(negedge clk);
        in_valid       <= 1'b1;
        opcode         <= row.op;
        base_value     <= row.base;
        exponent_value <= row.expo;
        do @(posedge clk); while (!in_ready);
        want = mod_power(row.op, row.base, row.expo, cur_modulus);
        if (row.has_exp && want != row.exp_val)
            report_mismatch("predictor vs table", want, row.exp_val);
        pending_results.insert(pending_results.size(), row.has_exp ? row.exp_val : want);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic stim_row_t mk(logic op, logic [BASE_BITS-1:0] b,
                                     logic [EXP_BITS-1:0] e, logic has,
                                     logic [RES_BITS-1:0] v);
        stim_row_t r;
        r.op = op; r.base = b; r.expo = e; r.has_exp = has; r.exp_val = v;
        return r;
    endfunction

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    // receiver draws a random wait after each accepted word
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rx_count != rx_seen)
            begin
                rx_seen = rx_count;
                rx_wait = $urandom_range(0, 3);
            end
            if (rx_wait == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            rx_count++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result_value", result_value, '0);
            else if (result_value != pending_results[0])
                report_mismatch("result_value", result_value, pending_results.pop_front());
            else
                void'(pending_results.pop_front());
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_BITS-1:0] moduli[7];
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset modulus
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, 63'd0, 63'd0, 1'b1, 31'd1));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, 63'd0, 63'd5, 1'b1, 31'd0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, 63'd2, 63'd10, 1'b1, 31'd1024));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, 63'd1000000007, 63'd3, 1'b1, 31'd0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, {63{1'b1}}, {63{1'b1}}, 1'b0, '0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, {63{1'b1}}, 63'd1, 1'b0, '0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, 63'd5, {63{1'b1}}, 1'b0, '0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_INVERSE, 63'd2, {63{1'b1}}, 1'b1, 31'd500000004));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_INVERSE, 63'd1, 63'd0, 1'b1, 31'd1));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_INVERSE, 63'd0, 63'd7, 1'b1, 31'd0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_INVERSE, {63{1'b1}}, 63'd0, 1'b0, '0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, 63'h2aaa_aaaa_aaaa_aaaa, 63'h5555_5555_5555_5555,
                                1'b0, '0));
        directed_rows.insert(directed_rows.size(),
                             mk(OP_POWER, 63'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaaa,
                                1'b0, '0));
        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        wait_drained();

        // modulus extremes: one, zero, two
        write_modulus(31'd1);
        send_request(mk(OP_POWER, 63'd9, 63'd0, 1'b1, 31'd1));
        send_request(mk(OP_POWER, 63'd9, 63'd4, 1'b1, 31'd0));
        send_request(mk(OP_INVERSE, 63'd9, 63'd4, 1'b1, 31'd1));
        wait_drained();
        write_modulus(31'd0);
        send_request(mk(OP_POWER, 63'd9, 63'd0, 1'b1, 31'd0));
        send_request(mk(OP_INVERSE, 63'd3, 63'd1, 1'b1, 31'd0));
        wait_drained();
        write_modulus(31'd2);
        send_request(mk(OP_INVERSE, 63'd3, 63'd1, 1'b1, 31'd1));
        send_request(mk(OP_POWER, 63'd3, 63'd5, 1'b1, 31'd1));
        wait_drained();

        // random part over several moduli, extremes included
        moduli = '{31'h7fff_ffff, 31'd13, 31'd2147483629, 31'd1, 31'd1000000007,
                   31'd65537, 31'd0};
        foreach (moduli[k])
        begin
            write_modulus(k == 6 ? 31'($urandom()) : moduli[k]);
            for (int n = 0; n < 38; n++)
            begin
                logic [62:0] e;
                e = rand63();
                // mostly short exponents to keep the run fast, some full width
                if ($urandom_range(0, 3) != 0)
                    e = e >> $urandom_range(40, 62);
                send_request(mk(1'($urandom_range(0, 3) == 0), rand63() >> $urandom_range(0, 62),
                                e, 1'b0, '0));
                if (n == 20)
                    while (pending_results.size() != 0)
                        @(posedge clk);
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### sim.f
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/mexp_datapath.sv
src/mexp_ctrl.sv
src/modular_exponentiation_core.sv
tb/sv/testbench.sv
